[design/idm_pkg.sv]
// Package for the IDM speed update pipeline: fixed-point constants,
// stage schedule, configuration register indexes and the pipeline item type.
// No dependencies.
package idm_pkg;

  localparam int ACCEL_EXPONENT = 4;

  localparam logic [25:0] STOP_MARGIN = 26'd512;
  localparam logic [25:0] MIN_GAP     = 26'd26;
  localparam logic [31:0] RATIO_CAP   = 32'h8000_0000;
  localparam logic [31:0] Q16_ONE     = 32'h0001_0000;
  localparam logic [25:0] R2_LIMIT    = 26'h100_0000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DESIRED_SPEED  = 3'd0;
  localparam logic [2:0] CFG_TIME_HEADWAY   = 3'd1;
  localparam logic [2:0] CFG_MAX_ACCEL      = 3'd2;
  localparam logic [2:0] CFG_COMFORT_DECEL  = 3'd3;
  localparam logic [2:0] CFG_JAM_DISTANCE   = 3'd4;
  localparam logic [2:0] CFG_VEHICLE_LENGTH = 3'd5;
  localparam logic [2:0] CFG_TIME_STEP      = 3'd6;

  // Stage schedule. The free-road ratio v / v0 and its power run beside the
  // square root and the dynamic spacing division.
  localparam int ST_IN      = 0;
  localparam int ST_PROD    = 1;
  localparam int SQ_FIRST   = 2;
  localparam int SQ_STEPS   = 12;
  localparam int DN_INIT    = SQ_FIRST + SQ_STEPS;
  localparam int DN_FIRST   = DN_INIT + 1;
  localparam int DN_STEPS   = 32;
  localparam int ST_SSTAR   = DN_FIRST + DN_STEPS;
  localparam int R2_FIRST   = ST_SSTAR + 1;
  localparam int R2_STEPS   = 26;
  localparam int ST_P2      = R2_FIRST + R2_STEPS;
  localparam int R1_FIRST   = 2;
  localparam int R1_STEPS   = 32;
  localparam int P1_FIRST   = R1_FIRST + R1_STEPS;
  localparam int ST_TERM    = ST_P2 + 1;
  localparam int ST_M1      = ST_TERM + 1;
  localparam int ST_M2      = ST_M1 + 1;
  localparam int ST_NV      = ST_M2 + 1;
  localparam int ST_DIST    = ST_NV + 1;
  localparam int NUM_STAGES = ST_DIST + 1;

  typedef struct packed {
    logic [15:0] v;
    logic        have_gap;
    logic [23:0] gap;
    logic [16:0] dv;
    logic        vdv_neg;
    logic [31:0] vdv_mag;
    logic [19:0] vt_prod;
    logic [23:0] sq_ab;
    logic [14:0] sq_rem;
    logic [11:0] sq_root;
    logic [12:0] dn_div;
    logic [12:0] dn_rem;
    logic [31:0] dn_num;
    logic        r2_sat;
    logic [23:0] r2_rem;
    logic [25:0] r2_num;
    logic [15:0] r1_rem;
    logic [31:0] r1_num;
    logic [31:0] p1;
    logic [31:0] p2;
    logic        term_neg;
    logic [32:0] mag;
    logic [44:0] m1;
    logic [28:0] dmag;
    logic [15:0] nv;
    logic [15:0] adv;
  } item_t;

endpackage

[design/idm_speed_update.sv]
// Intelligent driver model speed update, one vehicle per cycle.
// Throughput: one request per cycle; busy_o stays low and the receiver cannot stall.
// The depth is set by the serial dividers, one quotient bit per stage: the square
// root, the dynamic spacing division and the gap ratio division run one after another.
// Reset clears all valid bits and loads the default configuration registers.
// Depends on idm_pkg.
module idm_speed_update import idm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] own_speed_i,
  input  logic        leader_present_i,
  input  logic [23:0] leader_distance_i,
  input  logic [15:0] leader_speed_i,
  input  logic        red_light_ahead_i,
  input  logic [23:0] stop_line_distance_i,
  output logic        done_o,
  output logic [15:0] new_speed_o,
  output logic [15:0] distance_advanced_o
);

  logic [15:0] desired_speed_q;
  logic [11:0] time_headway_q;
  logic [11:0] max_accel_q;
  logic [11:0] comfort_decel_q;
  logic [15:0] jam_distance_q;
  logic [15:0] vehicle_length_q;
  logic [15:0] time_step_q;
  logic [15:0] v0;

  item_t                 pipe_q [NUM_STAGES];
  item_t                 pipe_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] valid_q;

  assign busy_o = 1'b0;
  assign v0 = (desired_speed_q == '0) ? 16'd1 : desired_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desired_speed_q  <= 16'd7680;
      time_headway_q   <= 12'd384;
      max_accel_q      <= 12'd256;
      comfort_decel_q  <= 12'd384;
      jam_distance_q   <= 16'd512;
      vehicle_length_q <= 16'd1152;
      time_step_q      <= 16'd1092;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DESIRED_SPEED:  desired_speed_q  <= cfg_wdata_i;
        CFG_TIME_HEADWAY:   time_headway_q   <= cfg_wdata_i[11:0];
        CFG_MAX_ACCEL:      max_accel_q      <= cfg_wdata_i[11:0];
        CFG_COMFORT_DECEL:  comfort_decel_q  <= cfg_wdata_i[11:0];
        CFG_JAM_DISTANCE:   jam_distance_q   <= cfg_wdata_i;
        CFG_VEHICLE_LENGTH: vehicle_length_q <= cfg_wdata_i;
        CFG_TIME_STEP:      time_step_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Entry stage: pick the nearer obstacle and form the speed difference.
  always_comb begin
    logic [25:0] gap_car;
    logic [23:0] gap_light;
    logic        use_light;
    logic [25:0] gap_sel;
    logic [15:0] vt;
    pipe_d[ST_IN] = '0;
    gap_car   = {2'b0, leader_distance_i} - {10'b0, vehicle_length_q} - STOP_MARGIN;
    gap_light = (stop_line_distance_i >= STOP_MARGIN[23:0]) ?
                (stop_line_distance_i - STOP_MARGIN[23:0]) : 24'd0;
    use_light = red_light_ahead_i &&
                (!leader_present_i || ($signed({2'b0, gap_light}) < $signed(gap_car)));
    if (use_light) begin
      gap_sel = {2'b0, gap_light};
      vt      = 16'd0;
    end else if (leader_present_i) begin
      gap_sel = gap_car;
      vt      = leader_speed_i;
    end else begin
      gap_sel = 26'd0;
      vt      = 16'd0;
    end
    if ($signed(gap_sel) < $signed(MIN_GAP)) begin
      gap_sel = MIN_GAP;
    end
    pipe_d[ST_IN].v        = own_speed_i;
    pipe_d[ST_IN].have_gap = use_light || leader_present_i;
    pipe_d[ST_IN].gap      = gap_sel[23:0];
    pipe_d[ST_IN].dv       = {1'b0, own_speed_i} - {1'b0, vt};
  end

  for (genvar s = 1; s < NUM_STAGES; s++) begin : g_stage
    always_comb begin
      item_t       d;
      logic [16:0] dv_abs;
      logic [27:0] vt_full;
      logic [14:0] sq_t;
      logic [14:0] sq_trial;
      logic [11:0] sq_fix;
      logic [13:0] dn_t;
      logic [16:0] r1_t;
      logic [24:0] r2_t;
      logic [33:0] dyn;
      logic [33:0] dynsum;
      logic [33:0] sstar;
      logic [31:0] r1_cap;
      logic [63:0] p1_prod;
      logic [49:0] r2_prod;
      logic [33:0] term;
      logic [33:0] term_abs;
      logic [61:0] m2_sum;
      logic [29:0] nv_up;
      logic [31:0] dist_prod;
      dv_abs    = '0;
      vt_full   = '0;
      sq_t      = '0;
      sq_trial  = '0;
      sq_fix    = '0;
      dn_t      = '0;
      r1_t      = '0;
      r2_t      = '0;
      dyn       = '0;
      dynsum    = '0;
      sstar     = '0;
      r1_cap    = '0;
      p1_prod   = '0;
      r2_prod   = '0;
      term      = '0;
      term_abs  = '0;
      m2_sum    = '0;
      nv_up     = '0;
      dist_prod = '0;
      d = pipe_q[s-1];

      if (s == ST_PROD) begin
        dv_abs    = d.dv[16] ? (17'd0 - d.dv) : d.dv;
        d.vdv_neg = d.dv[16];
        d.vdv_mag = {16'b0, d.v} * {16'b0, dv_abs[15:0]};
        vt_full   = {12'b0, d.v} * {16'b0, time_headway_q};
        d.vt_prod = vt_full[27:8];
        d.sq_ab   = {12'b0, max_accel_q} * {12'b0, comfort_decel_q};
        d.sq_rem  = '0;
        d.sq_root = '0;
        d.r1_num  = {d.v, 16'b0};
        d.r1_rem  = '0;
        d.p1      = Q16_ONE;
      end

      // Square root of a*b, one result bit per stage.
      if (s >= SQ_FIRST && s < SQ_FIRST + SQ_STEPS) begin
        sq_t     = {d.sq_rem[12:0], d.sq_ab[23:22]};
        sq_trial = {1'b0, d.sq_root, 2'b01};
        if (sq_t >= sq_trial) begin
          d.sq_rem  = sq_t - sq_trial;
          d.sq_root = {d.sq_root[10:0], 1'b1};
        end else begin
          d.sq_rem  = sq_t;
          d.sq_root = {d.sq_root[10:0], 1'b0};
        end
        d.sq_ab = {d.sq_ab[21:0], 2'b00};
      end

      // Free-road ratio v / v0 in Q16, one quotient bit per stage.
      if (s >= R1_FIRST && s < R1_FIRST + R1_STEPS) begin
        r1_t = {d.r1_rem, d.r1_num[31]};
        if (r1_t >= {1'b0, v0}) begin
          r1_t     = r1_t - {1'b0, v0};
          d.r1_num = {d.r1_num[30:0], 1'b1};
        end else begin
          d.r1_num = {d.r1_num[30:0], 1'b0};
        end
        d.r1_rem = r1_t[15:0];
      end

      // Saturating power of the free-road ratio, one product per stage.
      if (s >= P1_FIRST && s < P1_FIRST + ACCEL_EXPONENT) begin
        r1_cap  = (d.r1_num > RATIO_CAP) ? RATIO_CAP : d.r1_num;
        p1_prod = {32'b0, d.p1} * {32'b0, r1_cap};
        d.p1    = (p1_prod[63:16] > {16'b0, RATIO_CAP}) ? RATIO_CAP : p1_prod[47:16];
      end

      if (s == DN_INIT) begin
        sq_fix   = (d.sq_root == '0) ? 12'd1 : d.sq_root;
        d.dn_div = {sq_fix, 1'b0};
        d.dn_rem = '0;
        d.dn_num = d.vdv_mag;
      end

      // |v*dv| / (2*sq), one quotient bit per stage.
      if (s >= DN_FIRST && s < DN_FIRST + DN_STEPS) begin
        dn_t = {d.dn_rem, d.dn_num[31]};
        if (dn_t >= {1'b0, d.dn_div}) begin
          dn_t     = dn_t - {1'b0, d.dn_div};
          d.dn_num = {d.dn_num[30:0], 1'b1};
        end else begin
          d.dn_num = {d.dn_num[30:0], 1'b0};
        end
        d.dn_rem = dn_t[12:0];
      end

      // Desired spacing, and the ratio division set up with its top part
      // already reduced. A quotient of 2^26 or more saturates at once.
      if (s == ST_SSTAR) begin
        dyn    = d.vdv_neg ? (34'd0 - {2'b0, d.dn_num}) : {2'b0, d.dn_num};
        dynsum = {14'b0, d.vt_prod} + dyn;
        if (dynsum[33]) begin
          dynsum = '0;
        end
        sstar    = {18'b0, jam_distance_q} + {1'b0, dynsum[32:0]};
        d.r2_sat = (sstar >= {d.gap, 10'b0});
        d.r2_rem = sstar[33:10];
        d.r2_num = {sstar[9:0], 16'b0};
      end

      if (s >= R2_FIRST && s < R2_FIRST + R2_STEPS) begin
        r2_t = {d.r2_rem, d.r2_num[25]};
        if (r2_t >= {1'b0, d.gap}) begin
          r2_t     = r2_t - {1'b0, d.gap};
          d.r2_num = {d.r2_num[24:0], 1'b1};
        end else begin
          d.r2_num = {d.r2_num[24:0], 1'b0};
        end
        d.r2_rem = r2_t[23:0];
      end

      if (s == ST_P2) begin
        r2_prod = {25'b0, d.r2_num[24:0]} * {25'b0, d.r2_num[24:0]};
        if (!d.have_gap) begin
          d.p2 = '0;
        end else if (d.r2_sat || (d.r2_num > R2_LIMIT)) begin
          d.p2 = RATIO_CAP;
        end else begin
          d.p2 = (r2_prod[49:16] > {2'b0, RATIO_CAP}) ? RATIO_CAP : r2_prod[47:16];
        end
      end

      if (s == ST_TERM) begin
        term       = {2'b0, Q16_ONE} - {2'b0, d.p1} - {2'b0, d.p2};
        term_abs   = 34'd0 - term;
        d.term_neg = term[33];
        d.mag      = term[33] ? term_abs[32:0] : term[32:0];
      end

      if (s == ST_M1) begin
        d.m1 = {12'b0, d.mag} * {33'b0, max_accel_q};
      end

      // Round to nearest, halves away from zero, on the magnitude.
      if (s == ST_M2) begin
        m2_sum = {1'b0, {16'b0, d.m1} * {45'b0, time_step_q}} + (62'd1 << 31);
        d.dmag = m2_sum[60:32];
      end

      if (s == ST_NV) begin
        if (d.term_neg) begin
          d.nv = (d.dmag > {13'b0, d.v}) ? 16'd0 : (d.v - d.dmag[15:0]);
        end else begin
          nv_up = {14'b0, d.v} + {1'b0, d.dmag};
          d.nv  = (nv_up > 30'd65535) ? 16'hFFFF : nv_up[15:0];
        end
      end

      if (s == ST_DIST) begin
        dist_prod = {16'b0, d.nv} * {16'b0, time_step_q} + 32'd32768;
        d.adv     = dist_prod[31:16];
      end

      pipe_d[s] = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NUM_STAGES-2:0], start_i && !busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      pipe_q[i] <= pipe_d[i];
    end
  end

  assign done_o              = valid_q[NUM_STAGES-1];
  assign new_speed_o         = pipe_q[NUM_STAGES-1].nv;
  assign distance_advanced_o = pipe_q[NUM_STAGES-1].adv;

  // Every accepted request comes out after the full pipeline depth, and nothing else does.
  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##NUM_STAGES done_o)
    else $error("accepted request did not produce a result");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##NUM_STAGES !done_o)
    else $error("result without a request");

  a_stop_no_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (new_speed_o == '0) |-> (distance_advanced_o == '0))
    else $error("distance advanced while standing");

  a_accel_not_slower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_NV] && !pipe_q[ST_NV].term_neg |-> (pipe_q[ST_NV].nv >= pipe_q[ST_NV].v))
    else $error("speed dropped under positive acceleration");

endmodule
